### rtl/core/rcw_pkg.sv
// Shared widths, wheel constants and color mode codes for the radial
// color wave pixel generator. No dependencies.
`default_nettype none

package rcw_pkg;

    // Item field widths
    localparam int COORD_W  = 4;
    localparam int CTR_W    = 8;
    localparam int PHASE_W  = 6;
    localparam int CHAN_W   = 4;
    localparam int MODE_W   = 3;

    // Datapath widths
    localparam int DIFF_W   = 8;            // |pixel*16 - center|, Q4.4
    localparam int PROD_W   = 2 * DIFF_W;   // one square
    localparam int SQ_W     = PROD_W + 1;   // dx^2 + dy^2, Q9.8
    localparam int NINE_W   = SQ_W + 4;     // 9 * d2
    localparam int FRAC_DROP = 8;           // floor(sqrt(x)/16) = isqrt(x >> 8)
    localparam int RAD_W    = NINE_W - FRAC_DROP;
    localparam int ROOT_W   = (RAD_W + 1) / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int SUM_W    = 8;            // root + phase, at most 130
    localparam int STEP_W   = 6;

    // Wheel geometry
    localparam int WHEEL_STEPS = 48;
    localparam int SEG_LEN     = WHEEL_STEPS / 3;

    // Color mode register codes
    typedef enum logic [MODE_W-1:0] {
        MODE_RED   = 3'd0,
        MODE_GREEN = 3'd1,
        MODE_BLUE  = 3'd2,
        MODE_WHITE = 3'd3,
        MODE_RGB   = 3'd4
    } t_color_mode;

endpackage

`default_nettype wire

### rtl/core/rcw_dist.sv
// Squared distance front end: offset, squares and the 9x scale that feeds
// the square root. Three pipeline stages. Depends on rcw_pkg.
`default_nettype none

module rcw_dist
    import rcw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [COORD_W-1:0] i_column,
    input  wire logic [COORD_W-1:0] i_row,
    input  wire logic [CTR_W-1:0]   i_center_x,
    input  wire logic [CTR_W-1:0]   i_center_y,
    input  wire logic [PHASE_W-1:0] i_phase,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [RAD_W-1:0]        o_radicand,
    output logic [PHASE_W-1:0]      o_phase
);

    logic                r_v1, r_v2, r_v3;
    logic [DIFF_W-1:0]   r_dx, r_dy;
    logic [SQ_W-1:0]     r_d2;
    logic [RAD_W-1:0]    r_rad;
    logic [PHASE_W-1:0]  r_ph1, r_ph2, r_ph3;

    logic                w_rdy1, w_rdy2, w_rdy3;
    logic [DIFF_W-1:0]   w_px, w_py, n_dx, n_dy;
    logic [PROD_W-1:0]   w_sqx, w_sqy;
    logic [SQ_W-1:0]     n_d2;
    logic [NINE_W-1:0]   w_nine;

    // A stage takes a new item when empty or when it hands its own one on
    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // Stage 1: absolute offsets in Q4.4
    assign w_px = {i_column, 4'b0000};
    assign w_py = {i_row, 4'b0000};
    assign n_dx = (w_px >= i_center_x) ? (w_px - i_center_x) : (i_center_x - w_px);
    assign n_dy = (w_py >= i_center_y) ? (w_py - i_center_y) : (i_center_y - w_py);

    // Stage 2: squared distance
    assign w_sqx = r_dx * r_dx;
    assign w_sqy = r_dy * r_dy;
    assign n_d2  = SQ_W'(w_sqx) + SQ_W'(w_sqy);

    // Stage 3: 9*d2 by shift-add, fractional byte dropped
    assign w_nine = {r_d2, 3'b000} + NINE_W'(r_d2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_ph1 <= i_phase;
        end
        if (w_rdy2 && r_v1) begin
            r_d2  <= n_d2;
            r_ph2 <= r_ph1;
        end
        if (w_rdy3 && r_v2) begin
            r_rad <= w_nine[NINE_W-1:FRAC_DROP];
            r_ph3 <= r_ph2;
        end
    end

    assign o_valid    = r_v3;
    assign o_radicand = r_rad;
    assign o_phase    = r_ph3;

endmodule

`default_nettype wire

### rtl/core/rcw_isqrt.sv
// Pipelined floor integer square root, one result bit per stage
// (restoring digit recurrence). Depends on rcw_pkg.
`default_nettype none

module rcw_isqrt
    import rcw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [RAD_W-1:0]   i_radicand,
    input  wire logic [PHASE_W-1:0] i_phase,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [ROOT_W-1:0]       o_root,
    output logic [PHASE_W-1:0]      o_phase
);

    localparam int PAD_W = 2 * ROOT_W;

    logic                r_v    [ROOT_W];
    logic [REM_W-1:0]    r_rem  [ROOT_W];
    logic [ROOT_W-1:0]   r_root [ROOT_W];
    logic [PAD_W-1:0]    r_rad  [ROOT_W];
    logic [PHASE_W-1:0]  r_ph   [ROOT_W];

    logic [ROOT_W:0]     w_rdy;
    logic                w_v_in    [ROOT_W];
    logic [REM_W-1:0]    w_rem_in  [ROOT_W];
    logic [ROOT_W-1:0]   w_root_in [ROOT_W];
    logic [PAD_W-1:0]    w_rad_in  [ROOT_W];
    logic [PHASE_W-1:0]  w_ph_in   [ROOT_W];

    assign w_rdy[ROOT_W] = i_ready;
    assign o_ready       = w_rdy[0];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0]  w_cur;
        logic [REM_W-1:0]  w_trial;
        logic              w_ge;

        // Stage inputs: the pipe entry or the previous stage
        if (k == 0) begin : g_first
            assign w_v_in[k]    = i_valid;
            assign w_rem_in[k]  = '0;
            assign w_root_in[k] = '0;
            assign w_rad_in[k]  = PAD_W'(i_radicand);
            assign w_ph_in[k]   = i_phase;
        end else begin : g_next
            assign w_v_in[k]    = r_v[k-1];
            assign w_rem_in[k]  = r_rem[k-1];
            assign w_root_in[k] = r_root[k-1];
            assign w_rad_in[k]  = r_rad[k-1];
            assign w_ph_in[k]   = r_ph[k-1];
        end

        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];

        // Bring down the next bit pair, try (root << 2) | 1
        assign w_cur   = {w_rem_in[k][REM_W-3:0], w_rad_in[k][2*(ROOT_W-1-k) +: 2]};
        assign w_trial = REM_W'({w_root_in[k], 2'b01});
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= w_v_in[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k] && w_v_in[k]) begin
                r_rem[k]  <= w_ge ? (w_cur - w_trial) : w_cur;
                r_root[k] <= {w_root_in[k][ROOT_W-2:0], w_ge};
                r_rad[k]  <= w_rad_in[k];
                r_ph[k]   <= w_ph_in[k];
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_phase = r_ph[ROOT_W-1];

endmodule

`default_nettype wire

### rtl/core/rcw_color.sv
// Wheel step (mod 48), blue-red-green wheel lookup and color mode routing.
// Two stages; the second is the block's output register. Depends on rcw_pkg.
`default_nettype none

module rcw_color
    import rcw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [MODE_W-1:0]  i_color_mode,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [ROOT_W-1:0]  i_root,
    input  wire logic [PHASE_W-1:0] i_phase,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [CHAN_W-1:0]       o_red,
    output logic [CHAN_W-1:0]       o_green,
    output logic [CHAN_W-1:0]       o_blue,
    output logic [CHAN_W-1:0]       o_white
);

    logic                r_v1, r_v2;
    logic [STEP_W-1:0]   r_step;
    logic [CHAN_W-1:0]   r_red, r_green, r_blue, r_white;

    logic                w_rdy1, w_rdy2;
    logic [SUM_W-1:0]    w_sum;
    logic [STEP_W-1:0]   n_step;
    logic [CHAN_W-1:0]   w_r, w_g, w_b;
    logic [CHAN_W-1:0]   n_red, n_green, n_blue, n_white;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // Stage 1: step = (root + phase) mod 48; the sum stays below 3*48
    assign w_sum = SUM_W'(i_root) + SUM_W'(i_phase);
    always_comb begin
        if (w_sum >= SUM_W'(2 * WHEEL_STEPS)) begin
            n_step = STEP_W'(w_sum - SUM_W'(2 * WHEEL_STEPS));
        end else if (w_sum >= SUM_W'(WHEEL_STEPS)) begin
            n_step = STEP_W'(w_sum - SUM_W'(WHEEL_STEPS));
        end else begin
            n_step = STEP_W'(w_sum);
        end
    end

    // Stage 2: wheel segments blue->red, red->green, green->blue
    always_comb begin
        if (r_step < STEP_W'(SEG_LEN)) begin
            w_r = CHAN_W'(r_step);
            w_g = '0;
            w_b = CHAN_W'(STEP_W'(SEG_LEN - 1) - r_step);
        end else if (r_step < STEP_W'(2 * SEG_LEN)) begin
            w_r = CHAN_W'(STEP_W'(2 * SEG_LEN - 1) - r_step);
            w_g = CHAN_W'(r_step - STEP_W'(SEG_LEN));
            w_b = '0;
        end else begin
            w_r = '0;
            w_g = CHAN_W'(STEP_W'(3 * SEG_LEN - 1) - r_step);
            w_b = CHAN_W'(r_step - STEP_W'(2 * SEG_LEN));
        end
    end

    // Route channels by mode; unused codes give a black pixel
    always_comb begin
        n_red   = '0;
        n_green = '0;
        n_blue  = '0;
        n_white = '0;
        unique case (i_color_mode)
            MODE_RED:   n_red   = w_r;
            MODE_GREEN: n_green = w_g;
            MODE_BLUE:  n_blue  = w_b;
            MODE_WHITE: n_white = w_r;
            MODE_RGB: begin
                n_red   = w_r;
                n_green = w_g;
                n_blue  = w_b;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_step <= n_step;
        end
        if (w_rdy2 && r_v1) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_white <= n_white;
        end
    end

    assign o_valid = r_v2;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_white = r_white;

endmodule

`default_nettype wire

### rtl/core/radial_color_wave_pixel.sv
// Top level of the radial color wave pixel generator: input skid register,
// color mode register and the distance, square root and color pipeline.
// Depends on rcw_pkg, rcw_dist, rcw_isqrt and rcw_color.
`default_nettype none

// Takes one pixel request per clock while i_stall is low (column, row, Q4.4 wave
// center, phase) and returns one pixel (red, green, blue, white, 4 bits each) per
// request, in order. Throughput is one item per cycle while i_stall is low.
// An item passes through 3 distance stages, 7 square root stages (one root bit
// each) and 2 color stages, the first distance stage loading at the accepting
// edge. The skid register is out of the path while the pipe entry is free; it
// only holds an item taken while the pipe entry is full. Each stage holds its
// item while the stage after it cannot take it, so bubbles collapse, and
// o_stall comes straight from the registered skid stage. color_mode is sampled
// at the last stage, so write it only while no item is in flight.
module radial_color_wave_pixel
    import rcw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [MODE_W-1:0]  i_cfg_wr_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [COORD_W-1:0] i_column,
    input  wire logic [COORD_W-1:0] i_row,
    input  wire logic [CTR_W-1:0]   i_center_x,
    input  wire logic [CTR_W-1:0]   i_center_y,
    input  wire logic [PHASE_W-1:0] i_phase,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [CHAN_W-1:0]       o_red,
    output logic [CHAN_W-1:0]       o_green,
    output logic [CHAN_W-1:0]       o_blue,
    output logic [CHAN_W-1:0]       o_white
);

    logic [MODE_W-1:0]   r_color_mode;
    logic                r_skid_v;
    logic [COORD_W-1:0]  r_sk_column, r_sk_row;
    logic [CTR_W-1:0]    r_sk_cx, r_sk_cy;
    logic [PHASE_W-1:0]  r_sk_phase;

    logic                w_src_v, w_dist_rdy;
    logic [COORD_W-1:0]  w_src_column, w_src_row;
    logic [CTR_W-1:0]    w_src_cx, w_src_cy;
    logic [PHASE_W-1:0]  w_src_phase;

    logic                w_dist_v, w_sqrt_rdy;
    logic [RAD_W-1:0]    w_rad;
    logic [PHASE_W-1:0]  w_dist_ph;
    logic                w_sqrt_v, w_color_rdy;
    logic [ROOT_W-1:0]   w_root;
    logic [PHASE_W-1:0]  w_sqrt_ph;

    // Color mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= MODE_RED;
        end else if (i_cfg_wr_en) begin
            r_color_mode <= i_cfg_wr_data;
        end
    end

    // Skid stage: catches an item when the pipe entry is full
    assign o_stall = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_dist_rdy) r_skid_v <= 1'b0;
        end else if (i_valid && !w_dist_rdy) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v && i_valid && !w_dist_rdy) begin
            r_sk_column <= i_column;
            r_sk_row    <= i_row;
            r_sk_cx     <= i_center_x;
            r_sk_cy     <= i_center_y;
            r_sk_phase  <= i_phase;
        end
    end

    // Pipe entry source: the held item first
    assign w_src_v      = r_skid_v || i_valid;
    assign w_src_column = r_skid_v ? r_sk_column : i_column;
    assign w_src_row    = r_skid_v ? r_sk_row    : i_row;
    assign w_src_cx     = r_skid_v ? r_sk_cx     : i_center_x;
    assign w_src_cy     = r_skid_v ? r_sk_cy     : i_center_y;
    assign w_src_phase  = r_skid_v ? r_sk_phase  : i_phase;

    rcw_dist u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_src_v),
        .o_ready    (w_dist_rdy),
        .i_column   (w_src_column),
        .i_row      (w_src_row),
        .i_center_x (w_src_cx),
        .i_center_y (w_src_cy),
        .i_phase    (w_src_phase),
        .o_valid    (w_dist_v),
        .i_ready    (w_sqrt_rdy),
        .o_radicand (w_rad),
        .o_phase    (w_dist_ph)
    );

    rcw_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_dist_v),
        .o_ready    (w_sqrt_rdy),
        .i_radicand (w_rad),
        .i_phase    (w_dist_ph),
        .o_valid    (w_sqrt_v),
        .i_ready    (w_color_rdy),
        .o_root     (w_root),
        .o_phase    (w_sqrt_ph)
    );

    rcw_color u_color (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_color_mode (r_color_mode),
        .i_valid      (w_sqrt_v),
        .o_ready      (w_color_rdy),
        .i_root       (w_root),
        .i_phase      (w_sqrt_ph),
        .o_valid      (o_valid),
        .i_ready      (!i_stall),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_white      (o_white)
    );

endmodule

`default_nettype wire

### bench/radial_color_wave_pixel_tb.sv
// Self-checking bench for radial_color_wave_pixel: pixel requests go in under
// random gaps, and each pixel that comes out is checked against a local model.
// Depends on rcw_pkg and the radial_color_wave_pixel RTL.
`default_nettype none

module radial_color_wave_pixel_tb;
    import rcw_pkg::*;

    localparam int MAX_WAIT = 12;
    localparam int Q_ONE = 16;                 // 1.0 in Q4.4
    localparam int RAND_PER_PHASE = 48;
    localparam int DRAIN_CYCLES = 20;
    // codes above MODE_RGB have no name and give a black pixel
    localparam logic [MODE_W-1:0] MODE_UNUSED_TOP = '1;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [CTR_W-1:0]   center_x;
        logic [CTR_W-1:0]   center_y;
        logic [PHASE_W-1:0] phase;
    } t_pixel_req;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] white;
    } t_pixel_rgbw;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [MODE_W-1:0]  i_cfg_wr_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [COORD_W-1:0] i_column = '0;
    logic [COORD_W-1:0] i_row = '0;
    logic [CTR_W-1:0]   i_center_x = '0;
    logic [CTR_W-1:0]   i_center_y = '0;
    logic [PHASE_W-1:0] i_phase = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [CHAN_W-1:0]  o_red;
    logic [CHAN_W-1:0]  o_green;
    logic [CHAN_W-1:0]  o_blue;
    logic [CHAN_W-1:0]  o_white;

    t_pixel_req  pixel_q[$];       // requests waiting to be driven
    t_pixel_rgbw expected_pix_q[$]; // predicted pixels, oldest first
    logic [MODE_W-1:0] mode_model = MODE_RED;
    int send_wait = 0;
    int send_max = MAX_WAIT;
    int stall_left = 0;
    int stall_max = MAX_WAIT;
    int stall_draw;
    int mismatches = 0;

    radial_color_wave_pixel DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_column      (i_column),
        .i_row         (i_row),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_phase       (i_phase),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_white       (o_white)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Distance to the center, wheel step and mode routing for one request
    function automatic t_pixel_rgbw predict_pixel(input t_pixel_req q,
                                                  input logic [MODE_W-1:0] m);
        int dx, dy, rad, root, trial, step, r, g, b;
        t_pixel_rgbw p;
        dx = int'(q.column) * Q_ONE - int'(q.center_x);
        dy = int'(q.row) * Q_ONE - int'(q.center_y);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        // floor(3*dist) = isqrt(9*d2) / 16, root found bit by bit (< 2^11)
        rad = 9 * (dx * dx + dy * dy);
        root = 0;
        for (int k = 10; k >= 0; k--) begin
            trial = root | (1 << k);
            if (trial * trial <= rad) root = trial;
        end
        step = ((root >> 4) + int'(q.phase)) % WHEEL_STEPS;
        // blue-red, red-green, green-blue ramps
        if (step < SEG_LEN) begin
            r = step; g = 0; b = SEG_LEN - 1 - step;
        end else if (step < 2 * SEG_LEN) begin
            r = 2 * SEG_LEN - 1 - step; g = step - SEG_LEN; b = 0;
        end else begin
            r = 0; g = 3 * SEG_LEN - 1 - step; b = step - 2 * SEG_LEN;
        end
        p = '0;
        case (m)
            MODE_RED:   p.red = CHAN_W'(r);
            MODE_GREEN: p.green = CHAN_W'(g);
            MODE_BLUE:  p.blue = CHAN_W'(b);
            MODE_WHITE: p.white = CHAN_W'(r);
            MODE_RGB: begin
                p.red = CHAN_W'(r);
                p.green = CHAN_W'(g);
                p.blue = CHAN_W'(b);
            end
            default: p = '0;
        endcase
        return p;
    endfunction

    function automatic void check_chan(input string name, input logic [CHAN_W-1:0] exp_v,
                                       input logic [CHAN_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Driver: next request once the current one is taken and its gap has passed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_wait <= 0;
        end else begin
            if (i_valid && !o_stall)
                expected_pix_q.push_back(predict_pixel(
                    {i_column, i_row, i_center_x, i_center_y, i_phase}, mode_model));
            if (!i_valid || !o_stall) begin
                if (send_wait != 0) begin
                    send_wait <= send_wait - 1;
                    i_valid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    {i_column, i_row, i_center_x, i_center_y, i_phase} <= pixel_q.pop_front();
                    i_valid <= 1'b1;
                    send_wait <= $urandom_range(0, send_max);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken pixel, then stall for a random count
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (o_valid && !i_stall) begin
            if (expected_pix_q.size() == 0) begin
                $error("pixel out with none expected: r %0d g %0d b %0d w %0d",
                       o_red, o_green, o_blue, o_white);
                mismatches++;
            end else begin
                t_pixel_rgbw e;
                e = expected_pix_q.pop_front();
                check_chan("red", e.red, o_red);
                check_chan("green", e.green, o_green);
                check_chan("blue", e.blue, o_blue);
                check_chan("white", e.white, o_white);
            end
            stall_draw = $urandom_range(0, stall_max);
            stall_left <= stall_draw;
            i_stall <= (stall_draw != 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall <= (stall_left > 1);
        end
    end

    task automatic queue_req(input int c, input int r, input int x, input int y, input int p);
        t_pixel_req q;
        q.column = COORD_W'(c);
        q.row = COORD_W'(r);
        q.center_x = CTR_W'(x);
        q.center_y = CTR_W'(y);
        q.phase = PHASE_W'(p);
        pixel_q.push_back(q);
    endtask

    // Mostly panel pixels with in-range centers; about one in eight over full field range
    task automatic queue_random(input int n);
        repeat (n) begin
            if ($urandom_range(0, 7) != 0)
                queue_req($urandom_range(0, 11), $urandom_range(0, 15),
                          $urandom_range(32, 160), $urandom_range(32, 160),
                          $urandom_range(0, 47));
            else
                queue_req($urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 63));
        end
    endtask

    // Idle once nothing is queued, driven or outstanding
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pixel_q.size() != 0 || i_valid || expected_pix_q.size() != 0);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] m);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= m;
        mode_model = m;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        logic [MODE_W-1:0] plan [8];
        plan = '{MODE_RED, MODE_GREEN, MODE_BLUE, MODE_WHITE, MODE_UNUSED_TOP,
                 MODE_RGB, MODE_W'($urandom_range(0, (1 << MODE_W) - 1)), MODE_RGB};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset value of the mode, full idling on both sides
        queue_random(20);
        wait_drained();

        // directed: field extremes, zero distance across wheel boundaries
        write_mode(MODE_RGB);
        queue_req(0, 0, 32, 32, 0);
        queue_req(11, 15, 160, 160, 47);
        queue_req(15, 15, 0, 0, 63);
        queue_req(0, 0, 255, 255, 63);
        queue_req(15, 0, 0, 255, 47);
        foreach (plan[k]) queue_req(5, 5, 80, 80, k * 8 - 1 + (k == 0));
        queue_req(5, 5, 80, 80, 63);
        queue_req(12, 3, 96, 96, 10);
        queue_req(6, 8, 8'h5B, 8'hA7, 20);
        wait_drained();

        // random phases, one mode each, idling mixes including none at all
        foreach (plan[k]) begin
            write_mode(plan[k]);
            send_max = (k % 2 != 0) ? MAX_WAIT : 0;
            stall_max = (k % 4 >= 2) ? MAX_WAIT : 0;
            queue_random(RAND_PER_PHASE);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("radial_color_wave_pixel test passed");
        else
            $display("radial_color_wave_pixel test failed");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("radial_color_wave_pixel test failed");
        $finish;
    end

endmodule

`default_nettype wire
